// File: rtl/core/hsrk_pkg.sv
// Shared types for the record heapsort core.
// Holds the record, request and response layouts; no dependencies.
`timescale 1ns / 1ps

package hsrk_pkg;

   localparam int unsigned ID_W  = 6;
   localparam int unsigned KEY_W = 6;

   typedef struct packed {
      logic [ID_W-1:0]  vertex;
      logic [KEY_W-1:0] degree;
   } record_type;

   typedef struct packed {
      logic [ID_W-1:0]  vertex_id;
      logic [KEY_W-1:0] degree;
      logic             is_last;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]  out_vertex;
      logic [KEY_W-1:0] out_degree;
      logic             end_of_run;
   } rsp_type;

endpackage

// File: rtl/core/hsrk_store.sv
// Record store: one write port, two read ports with registered outputs.
// Depends on hsrk_pkg for the record layout.
`timescale 1ns / 1ps

module hsrk_store #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  hsrk_pkg::record_type          wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr_b,
   output hsrk_pkg::record_type          rd_data_a,
   output hsrk_pkg::record_type          rd_data_b
);

   hsrk_pkg::record_type mem [DEPTH];
   hsrk_pkg::record_type rd_a_ff;
   hsrk_pkg::record_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: rtl/core/heapsort_records_by_key_core.sv
// Top level of the record heapsort core: load, heap build, sort and drain sequencer.
// Depends on hsrk_pkg and hsrk_store.
//
// Usage:
//   req_ channel: one record per transaction (vertex_id, degree, is_last). Records
//   are stored one per cycle; records beyond DEPTH are dropped. A transaction with
//   is_last set closes the set and starts the sort; req_ready stays low until the
//   whole sorted set has been handed to the rsp_ channel.
//   rsp_ channel: n transactions in ascending degree, end_of_run set on the last.
//   Sort sequence: sorting runs on the two-read, one-write record store. Each build
//   sift starts with a read of its node and a hold step, and each root swap takes a
//   swap read and a swap write; then one compare-and-write step per heap level and a
//   final put step to place the held record when it sinks to a leaf. Draining moves
//   each record through a store read and then the output register.
//   Reset: synchronous; clears the record count, drops any sort in progress and clears
//   rsp_valid. The store needs no clearing pass.
//   Stall: while rsp_ready is low the output register holds its transaction and
//   the drain waits; no record is lost or repeated.
`timescale 1ns / 1ps

module heapsort_records_by_key_core #(
   parameter int unsigned DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hsrk_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hsrk_pkg::rsp_type rsp_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   localparam logic [2:0] ST_LOAD    = 3'd0;
   localparam logic [2:0] ST_START   = 3'd1;
   localparam logic [2:0] ST_HOLD    = 3'd2;
   localparam logic [2:0] ST_CMP     = 3'd3;
   localparam logic [2:0] ST_PUT     = 3'd4;
   localparam logic [2:0] ST_SWAP_RD = 3'd5;
   localparam logic [2:0] ST_SWAP_WR = 3'd6;
   localparam logic [2:0] ST_OUT     = 3'd7;

   logic [2:0]           state_ff,    state_in;
   logic [CW-1:0]        count_ff,    count_in;
   logic                 build_ff,    build_in;
   logic [AW-1:0]        s_ff,        s_in;
   logic [AW-1:0]        end_ff,      end_in;
   logic [AW-1:0]        last_ff,     last_in;
   logic [AW-1:0]        i_ff,        i_in;
   hsrk_pkg::record_type held_ff,     held_in;
   logic [CW-1:0]        k_ff,        k_in;
   logic                 out_pend_ff, out_pend_in;
   logic                 out_end_ff,  out_end_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   hsrk_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   hsrk_pkg::record_type mem_wdata;
   logic [AW-1:0]        mem_raddr_a;
   logic [AW-1:0]        mem_raddr_b;
   hsrk_pkg::record_type rdata_a;
   hsrk_pkg::record_type rdata_b;

   logic [AW:0]          child_base;
   logic [AW:0]          next_base;
   logic [AW:0]          last_ext;
   logic                 use_right;
   logic [AW-1:0]        child_idx;
   hsrk_pkg::record_type child_rec;
   logic [CW-1:0]        n_new;
   logic                 sift_end;

   hsrk_store #(.DEPTH(DEPTH)) u_store (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_addr_a (mem_raddr_a),
      .rd_addr_b (mem_raddr_b),
      .rd_data_a (rdata_a),
      .rd_data_b (rdata_b)
   );

   assign req_ready  = (state_ff == ST_LOAD);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign child_base = {i_ff, 1'b1};
   assign last_ext   = {1'b0, last_ff};
   assign use_right  = (child_base < last_ext) && (rdata_a.degree < rdata_b.degree);
   assign child_idx  = use_right ? (child_base[AW-1:0] + AW'(1)) : child_base[AW-1:0];
   assign child_rec  = use_right ? rdata_b : rdata_a;
   assign next_base  = {child_idx, 1'b1};
   assign n_new      = (count_ff < CW'(DEPTH)) ? (count_ff + CW'(1)) : count_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      build_in     = build_ff;
      s_in         = s_ff;
      end_in       = end_ff;
      last_in      = last_ff;
      i_in         = i_ff;
      held_in      = held_ff;
      k_in         = k_ff;
      out_pend_in  = out_pend_ff;
      out_end_in   = out_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = i_ff;
      mem_wdata    = held_ff;
      mem_raddr_a  = '0;
      mem_raddr_b  = '0;
      sift_end     = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (count_ff < CW'(DEPTH)) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[AW-1:0];
                  mem_wdata = '{vertex: req_data.vertex_id, degree: req_data.degree};
               end
               count_in = n_new;
               if (req_data.is_last) begin
                  last_in  = AW'(n_new - CW'(1));
                  build_in = 1'b1;
                  k_in     = '0;
                  if (n_new < CW'(2)) begin
                     state_in = ST_OUT;
                  end else begin
                     s_in     = AW'((n_new >> 1) - CW'(1));
                     state_in = ST_START;
                  end
               end
            end
         end
         ST_START: begin
            mem_raddr_a = s_ff;
            i_in        = s_ff;
            state_in    = ST_HOLD;
         end
         ST_HOLD: begin
            held_in = rdata_a;
            if (child_base <= last_ext) begin
               mem_raddr_a = child_base[AW-1:0];
               mem_raddr_b = child_base[AW-1:0] + AW'(1);
               state_in    = ST_CMP;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            if (held_ff.degree >= child_rec.degree) begin
               mem_wdata = held_ff;
               sift_end  = 1'b1;
            end else begin
               mem_wdata = child_rec;
               i_in      = child_idx;
               if (next_base <= last_ext) begin
                  mem_raddr_a = next_base[AW-1:0];
                  mem_raddr_b = next_base[AW-1:0] + AW'(1);
               end else begin
                  state_in = ST_PUT;
               end
            end
         end
         ST_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = held_ff;
            sift_end  = 1'b1;
         end
         ST_SWAP_RD: begin
            mem_raddr_a = '0;
            mem_raddr_b = end_ff;
            state_in    = ST_SWAP_WR;
         end
         ST_SWAP_WR: begin
            mem_we    = 1'b1;
            mem_waddr = end_ff;
            mem_wdata = rdata_a;
            held_in   = rdata_b;
            i_in      = '0;
            last_in   = end_ff - AW'(1);
            if ({1'b0, end_ff} >= (AW+1)'(2)) begin
               mem_raddr_a = AW'(1);
               mem_raddr_b = AW'(2);
               state_in    = ST_CMP;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_OUT: begin
            if (out_pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_vertex: rdata_a.vertex,
                                out_degree: rdata_a.degree,
                                end_of_run: out_end_ff};
               out_pend_in  = 1'b0;
               if (out_end_ff) begin
                  count_in = '0;
                  state_in = ST_LOAD;
               end
            end else if ((!rsp_valid_ff || rsp_ready) && (k_ff < count_ff)) begin
               mem_raddr_a = k_ff[AW-1:0];
               out_pend_in = 1'b1;
               out_end_in  = (k_ff == (count_ff - CW'(1)));
               k_in        = k_ff + CW'(1);
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // advance to the next sift, swap or drain once the held record is placed
      if (sift_end) begin
         if (build_ff) begin
            if (s_ff == '0) begin
               build_in = 1'b0;
               end_in   = last_ff;
               state_in = ST_SWAP_RD;
            end else begin
               s_in     = s_ff - AW'(1);
               state_in = ST_START;
            end
         end else begin
            if (end_ff == AW'(1)) begin
               k_in     = '0;
               state_in = ST_OUT;
            end else begin
               end_in   = end_ff - AW'(1);
               state_in = ST_SWAP_RD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         build_ff     <= 1'b0;
         out_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         build_ff     <= build_in;
         out_pend_ff  <= out_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      end_ff      <= end_in;
      last_ff     <= last_in;
      i_ff        <= i_in;
      held_ff     <= held_in;
      k_ff        <= k_in;
      out_end_ff  <= out_end_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_land_free: assert property (@(posedge clock) disable iff (reset)
      out_pend_ff |-> !rsp_valid_ff)
      else $error("store read landed while output register still occupied");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("record count beyond store depth");

   a_cmp_child: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (child_base <= last_ext))
      else $error("sift compare on a child outside the heap");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.is_last) |=> !req_ready)
      else $error("input still open after the closing transaction");

   a_drain_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> !mem_we)
      else $error("store written while draining");

endmodule
